[design/rti_pkg.sv]
package rti_pkg;

  localparam int unsigned CAPACITY_DEF = 32;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned IDENT_W  = 32;
  localparam int unsigned CVAL_W   = 31;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned COUNT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SETCOUNT = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_HIT  = 2'd3;

  localparam logic [CVAL_W-1:0] STAG_MAX = {CVAL_W{1'b1}};
  localparam logic [KEY_W-1:0]  KEY_NONE = {KEY_W{1'b1}};

  // Flags from the shared comparator
  typedef struct packed {
    logic gt;  // stored operand above the probe
    logic eq;  // operands equal
  } cmp_res_t;

endpackage

[design/rti_ram.sv]
module rti_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/rti_cmp.sv]
module rti_cmp
  import rti_pkg::*;
(
  input  logic [KEY_W-1:0] stored_i,
  input  logic [KEY_W-1:0] probe_i,
  output cmp_res_t         res_o
);

  // One subtractor serves both the key order test and the ident match
  logic [KEY_W:0] diff;

  assign diff     = {1'b0, probe_i} - {1'b0, stored_i};
  assign res_o.gt = diff[KEY_W];
  assign res_o.eq = (diff[KEY_W-1:0] == '0);

endmodule

[design/ranked_table_insert.sv]
// Channel | Direction | Handshake             | Payload
// in      | sink      | in_valid_i/in_ready_o | command_i key_i ident_i count_value_i
// out     | source    | out_valid_o/out_ready_i | status_o position_o best_key_o
//         |           |                       | worst_key_o entry_count_o stagnation_o
//
// One command at a time; in_ready_o is high only while the sequencer idles.
// From the input transfer: an insert walks keys from the tail, moving each
// larger entry down one place, then writes the newcomer; a lookup walks idents
// from the head to the first match or the end; clear, set and a refused insert
// go straight to the result. Each entry visited passes the single registered
// read port and then the shared comparator. Reset empties the table at once.
// A stalled result holds in the output register; the next command may be taken
// meanwhile and its result waits until that transfer completes.
module ranked_table_insert
  import rti_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [IDENT_W-1:0]  ident_i,
  input  logic [CVAL_W-1:0]   count_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [POS_W-1:0]    position_o,
  output logic [KEY_W-1:0]    best_key_o,
  output logic [KEY_W-1:0]    worst_key_o,
  output logic [COUNT_W-1:0]  entry_count_o,
  output logic [CVAL_W-1:0]   stagnation_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [CVAL_W-1:0]   stag_q, stag_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                out_valid_q, out_valid_d;

  // Latched command payload
  logic [CMD_W-1:0]   cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [IDENT_W-1:0] ident_q;
  logic [KEY_W-1:0]   best_q, best_d;
  logic [KEY_W-1:0]   worst_q, worst_d;

  logic [STATUS_W-1:0] out_status_q;
  logic [POS_W-1:0]    out_pos_q;
  logic [KEY_W-1:0]    out_best_q, out_worst_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [CVAL_W-1:0]   out_stag_q;

  logic               in_xfer, out_load;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [KEY_W-1:0]   wkey, rkey;
  logic [IDENT_W-1:0] wident, rident;
  logic [CW-1:0]      idx_inc;
  logic [31:0]        pos_wide, count_wide;
  cmp_res_t           cmp_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  assign idx_inc    = idx_q + CW'(1);
  assign raddr      = idx_q[AW-1:0];

  rti_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wkey),
    .raddr_i (raddr),
    .rdata_o (rkey)
  );

  rti_ram #(.WIDTH(IDENT_W), .DEPTH(CAPACITY)) u_ident_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wident),
    .raddr_i (raddr),
    .rdata_o (rident)
  );

  // Insert walks keys from the tail; lookup walks idents from the head
  rti_cmp u_cmp (
    .stored_i ((cmd_q == CMD_INSERT) ? rkey : rident),
    .probe_i  ((cmd_q == CMD_INSERT) ? key_q : ident_q),
    .res_o    (cmp_res)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    stag_d      = stag_q;
    status_d    = status_q;
    best_d      = best_q;
    worst_d     = worst_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = idx_inc[AW-1:0];
    wkey        = rkey;
    wident      = rident;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          status_d = STATUS_DONE;
          pos_d    = '0;
          state_d  = S_RESP;
          case (command_i)
            CMD_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = STATUS_FULL;
              end else if (count_q == '0) begin
                state_d = S_WRITE;
              end else begin
                idx_d   = count_q - CW'(1);
                state_d = S_READ;
              end
            end
            CMD_LOOKUP: begin
              if (count_q == '0) begin
                status_d = STATUS_MISS;
              end else begin
                idx_d   = '0;
                state_d = S_READ;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
              stag_d = count_value_i;
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (cmd_q == CMD_INSERT) begin
          if (cmp_res.gt) begin
            // Shift the larger entry down one place
            we = 1'b1;
            if (idx_q == '0) begin
              pos_d   = '0;
              state_d = S_WRITE;
            end else begin
              idx_d   = idx_q - CW'(1);
              state_d = S_READ;
            end
          end else begin
            pos_d   = idx_inc[AW-1:0];
            state_d = S_WRITE;
          end
        end else begin
          if (cmp_res.eq) begin
            status_d = STATUS_HIT;
            pos_d    = idx_q[AW-1:0];
            state_d  = S_RESP;
          end else if (idx_inc == count_q) begin
            status_d = STATUS_MISS;
            state_d  = S_RESP;
          end else begin
            idx_d   = idx_inc;
            state_d = S_READ;
          end
        end
      end
      S_WRITE: begin
        we      = 1'b1;
        waddr   = pos_q;
        wkey    = key_q;
        wident  = ident_q;
        count_d = count_q + CW'(1);
        if (pos_q == '0) begin
          best_d = key_q;
          stag_d = '0;
        end else if (stag_q != STAG_MAX) begin
          stag_d = stag_q + CVAL_W'(1);
        end
        if (CW'(pos_q) == count_q) begin
          worst_d = key_q;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        // Hold the result until the output register is free
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      stag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      stag_q      <= stag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    best_q   <= best_d;
    worst_q  <= worst_d;
    if (in_xfer) begin
      cmd_q   <= command_i;
      key_q   <= key_i;
      ident_q <= ident_i;
    end
  end

  assign pos_wide   = 32'(pos_q);
  assign count_wide = 32'(count_q);

  // Output register: loaded once the table state reflects the command
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_pos_q    <= pos_wide[POS_W-1:0];
      out_best_q   <= (count_q == '0) ? KEY_NONE : best_q;
      out_worst_q  <= (count_q == '0) ? KEY_NONE : worst_q;
      out_count_q  <= count_wide[COUNT_W-1:0];
      out_stag_q   <= stag_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign position_o    = out_pos_q;
  assign best_key_o    = out_best_q;
  assign worst_key_o   = out_worst_q;
  assign entry_count_o = out_count_q;
  assign stagnation_o  = out_stag_q;

endmodule

[dv/ranked_table_insert_tb.sv]
`timescale 1ns / 1ps

module ranked_table_insert_tb;
  import rti_pkg::*;

  localparam int unsigned TABLE_DEPTH  = CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  // Slowest command walks the whole table, reading and comparing every entry.
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 40;
  localparam int unsigned REPORT_CAP   = 40;
  localparam int unsigned POOL_SIZE    = 16;
  localparam int unsigned PLAN_ROWS    = 23;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [KEY_W-1:0]   key;
    logic [IDENT_W-1:0] ident;
    logic [CVAL_W-1:0]  count_value;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    best_key;
    logic [KEY_W-1:0]    worst_key;
    logic [COUNT_W-1:0]  entry_count;
    logic [CVAL_W-1:0]   stagnation;
  } outcome_t;

  // One row of the directed plan. A span above one repeats the command,
  // stepping the key by one integer unit and the identifier by one each time.
  // Rows marked fixed carry their outcome written out; the rest are predicted.
  typedef struct packed {
    command_t    item;
    logic [5:0]  span;
    logic        fixed;
    outcome_t    want;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // empty table after reset: lookup misses, keys read all ones
    '{'{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 31'h0}, 6'd1, 1'b1,
      '{STATUS_MISS, 5'd0, KEY_NONE, KEY_NONE, 6'd0, 31'd0}},
    '{'{CMD_CLEAR, KEY_NONE, 32'hFFFF_FFFF, STAG_MAX}, 6'd1, 1'b1,
      '{STATUS_DONE, 5'd0, KEY_NONE, KEY_NONE, 6'd0, 31'd0}},
    '{'{CMD_SETCOUNT, 32'h0000_0000, 32'h0000_0000, STAG_MAX}, 6'd1, 1'b1,
      '{STATUS_DONE, 5'd0, KEY_NONE, KEY_NONE, 6'd0, STAG_MAX}},
    // first entry lands first and clears the counter
    '{'{CMD_INSERT, 32'h8000_0000, 32'h0000_0001, 31'h0}, 6'd1, 1'b1,
      '{STATUS_DONE, 5'd0, 32'h8000_0000, 32'h8000_0000, 6'd1, 31'd0}},
    '{'{CMD_SETCOUNT, 32'h0000_0000, 32'h0000_0000, STAG_MAX}, 6'd1, 1'b1,
      '{STATUS_DONE, 5'd0, 32'h8000_0000, 32'h8000_0000, 6'd1, STAG_MAX}},
    // counter at its ceiling stays there on an insert behind the best
    '{'{CMD_INSERT, KEY_NONE, 32'hFFFF_FFFF, 31'h0}, 6'd1, 1'b1,
      '{STATUS_DONE, 5'd1, 32'h8000_0000, KEY_NONE, 6'd2, STAG_MAX}},
    // equal keys: the newcomer goes behind every equal entry
    '{'{CMD_INSERT, 32'h8000_0000, 32'h0000_0002, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_INSERT, KEY_NONE, 32'h0000_0003, STAG_MAX}, 6'd1, 1'b0, '0},
    // new best key
    '{'{CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 31'h0}, 6'd1, 1'b1,
      '{STATUS_DONE, 5'd0, 32'h0000_0000, KEY_NONE, 6'd5, 31'd0}},
    // duplicate identifier; lookup must report the lower position
    '{'{CMD_INSERT, 32'h0001_8000, 32'h0000_0002, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0002, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_LOOKUP, KEY_NONE, 32'hFFFF_FFFF, STAG_MAX}, 6'd1, 1'b0, '0},
    '{'{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_LOOKUP, 32'h5555_5555, 32'h1234_5678, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_SETCOUNT, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA}, 6'd1, 1'b0, '0},
    '{'{CMD_SETCOUNT, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555}, 6'd1, 1'b0, '0},
    // fill the table to the brim; the last of the run is refused
    '{'{CMD_INSERT, 32'h7FFF_0000, 32'h0000_0100, 31'h0}, 6'd27, 1'b0, '0},
    '{'{CMD_INSERT, 32'h0000_0000, 32'hDEAD_BEEF, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0119, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFE, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_CLEAR, 32'h0000_0000, 32'h0000_0000, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 31'h0}, 6'd1, 1'b0, '0},
    '{'{CMD_INSERT, KEY_NONE, 32'h0000_0000, 31'h0}, 6'd1, 1'b1,
      '{STATUS_DONE, 5'd0, KEY_NONE, KEY_NONE, 6'd1, 31'd0}}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i     = CMD_CLEAR;
  logic [KEY_W-1:0]    key_i         = '0;
  logic [IDENT_W-1:0]  ident_i       = '0;
  logic [CVAL_W-1:0]   count_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [POS_W-1:0]    position_o;
  logic [KEY_W-1:0]    best_key_o;
  logic [KEY_W-1:0]    worst_key_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic [CVAL_W-1:0]   stagnation_o;

  // Side band travelling with the offered command, sampled at its transfer.
  logic     row_is_fixed  = 1'b0;
  outcome_t fixed_outcome = '0;

  // Shadow of the sorted table, advanced on every input transfer.
  logic [KEY_W-1:0]   table_keys   [TABLE_DEPTH];
  logic [IDENT_W-1:0] table_idents [TABLE_DEPTH];
  int unsigned        table_fill       = 0;
  logic [CVAL_W-1:0]  table_stagnation = '0;

  outcome_t pending_outcomes [$];
  int unsigned failures = 0;

  int unsigned sender_idle_pct   = 29;
  int unsigned receiver_idle_pct = 71;
  bit          hold_pending      = 1'b0;

  logic [IDENT_W-1:0] ident_pool [POOL_SIZE];

  ranked_table_insert dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .ident_i      (ident_i),
    .count_value_i(count_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .best_key_o   (best_key_o),
    .worst_key_o  (worst_key_o),
    .entry_count_o(entry_count_o),
    .stagnation_o (stagnation_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Apply one command to the shadow table and work out the result it yields.
  task automatic predict_ranking(input command_t c, output outcome_t o);
    int unsigned         slot;
    logic [STATUS_W-1:0] verdict;
    logic [POS_W-1:0]    where;
    verdict = STATUS_DONE;
    where   = '0;
    case (c.command)
      CMD_INSERT: begin
        if (table_fill >= TABLE_DEPTH) begin
          verdict = STATUS_FULL;
        end else begin
          slot = 0;
          // land behind every entry with a lower or equal key
          while (slot < table_fill && table_keys[slot] <= c.key) slot++;
          for (int i = table_fill; i > slot; i--) begin
            table_keys[i]   = table_keys[i-1];
            table_idents[i] = table_idents[i-1];
          end
          table_keys[slot]   = c.key;
          table_idents[slot] = c.ident;
          table_fill++;
          if (slot == 0) begin
            table_stagnation = '0;
          end else if (table_stagnation != STAG_MAX) begin
            table_stagnation++;
          end
          where = POS_W'(slot);
        end
      end
      CMD_LOOKUP: begin
        verdict = STATUS_MISS;
        for (int i = 0; i < table_fill; i++) begin
          if (table_idents[i] == c.ident) begin
            verdict = STATUS_HIT;
            where   = POS_W'(i);
            break;
          end
        end
      end
      CMD_CLEAR: begin
        table_fill = 0;
      end
      default: begin
        table_stagnation = c.count_value;
      end
    endcase
    o.status      = verdict;
    o.position    = where;
    o.best_key    = (table_fill > 0) ? table_keys[0] : KEY_NONE;
    o.worst_key   = (table_fill > 0) ? table_keys[table_fill-1] : KEY_NONE;
    o.entry_count = COUNT_W'(table_fill);
    o.stagnation  = table_stagnation;
  endtask

  function automatic void flag_field(string field, logic [KEY_W-1:0] want,
                                     logic [KEY_W-1:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= REPORT_CAP) begin
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    end
  endfunction

  // Both channels are watched from one process: an input transfer is
  // predicted before any output transfer of the same edge is checked.
  always @(posedge clk_i) begin : watch_channels
    command_t offered;
    outcome_t predicted;
    outcome_t seen;
    outcome_t oldest;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        offered = {command_i, key_i, ident_i, count_value_i};
        predict_ranking(offered, predicted);
        pending_outcomes.insert(pending_outcomes.size(),
                                row_is_fixed ? fixed_outcome : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        seen = {status_o, position_o, best_key_o, worst_key_o, entry_count_o,
                stagnation_o};
        if (pending_outcomes.size() == 0) begin
          failures++;
          if (failures <= REPORT_CAP) begin
            $display("%0t ns: result transfer with nothing outstanding, got 0x%0h",
                     $time, seen);
          end
        end else begin
          oldest = pending_outcomes.pop_front();
          flag_field("status",      KEY_W'(oldest.status),      KEY_W'(seen.status));
          flag_field("position",    KEY_W'(oldest.position),    KEY_W'(seen.position));
          flag_field("best_key",    oldest.best_key,            seen.best_key);
          flag_field("worst_key",   oldest.worst_key,           seen.worst_key);
          flag_field("entry_count", KEY_W'(oldest.entry_count), KEY_W'(seen.entry_count));
          flag_field("stagnation",  KEY_W'(oldest.stagnation),  KEY_W'(seen.stagnation));
        end
      end
    end
  end

  // Result side: random back-pressure, or a long hold-off on request so
  // that a stalled result backs the block up into its input.
  initial begin : drive_receiver
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Offer one command and hold it until its transfer completes.
  task automatic offer(input command_t c, input logic fixed, input outcome_t want);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    {command_i, key_i, ident_i, count_value_i} <= c;
    row_is_fixed  <= fixed;
    fixed_outcome <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Keys cluster on a few values so that ties are common.
  function automatic logic [KEY_W-1:0] draw_key();
    case ($urandom_range(7))
      0:       return '0;
      1:       return KEY_NONE;
      2, 3, 4: return {16'($urandom_range(7)), 16'h8000};
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [CVAL_W-1:0] draw_count();
    case ($urandom_range(3))
      0:       return STAG_MAX - CVAL_W'($urandom_range(2));
      1:       return CVAL_W'($urandom_range(5));
      default: return CVAL_W'($urandom);
    endcase
  endfunction

  // Mostly inserts and lookups; clears are rare enough that the table
  // regularly fills and refuses inserts.
  function automatic command_t draw_command();
    command_t    c;
    int unsigned pick;
    pick          = $urandom_range(199);
    c.key         = draw_key();
    c.ident       = $urandom_range(1) ? ident_pool[$urandom_range(POOL_SIZE-1)]
                                      : IDENT_W'($urandom);
    c.count_value = draw_count();
    if (pick < 3) begin
      c.command = CMD_CLEAR;
    end else if (pick < 113) begin
      c.command = CMD_INSERT;
    end else if (pick < 173) begin
      c.command = CMD_LOOKUP;
    end else begin
      c.command = CMD_SETCOUNT;
    end
    return c;
  endfunction

  initial begin : drive_sender
    command_t item;
    for (int p = 0; p < POOL_SIZE; p++) ident_pool[p] = IDENT_W'($urandom);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      for (int k = 0; k < PLAN[r].span; k++) begin
        item       = PLAN[r].item;
        item.key   = item.key + KEY_W'(k << 16);
        item.ident = item.ident + IDENT_W'(k);
        offer(item, PLAN[r].fixed, PLAN[r].want);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) hold_pending = 1'b1;
      if (n == RANDOM_ITEMS / 3) begin
        sender_idle_pct   = 71;
        receiver_idle_pct = 29;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_pending      = 1'b1;
      end
      item = draw_command();
      if (item.command == CMD_INSERT) ident_pool[$urandom_range(POOL_SIZE-1)] = item.ident;
      offer(item, 1'b0, '0);
    end

    // drop valid, wait for the last results, then let the block settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
design/rti_pkg.sv
design/rti_ram.sv
design/rti_cmp.sv
design/ranked_table_insert.sv
dv/ranked_table_insert_tb.sv
